FILE: src/prpd_pkg.sv
`timescale 1ns / 1ps
package prpd_pkg;

  localparam int PIX_W   = 16;
  localparam int COMP_W  = 20;
  localparam int VEC_W   = 3 * COMP_W;
  localparam int SCALE_W = 32;
  localparam int PROD_W  = PIX_W + 1 + SCALE_W;   // (pix + 8) * scale
  localparam int WS_W    = 32;                    // signed plane scale, Q.16
  localparam int MP_W    = COMP_W + WS_W;         // component times plane scale
  localparam int D_W     = 54;                    // direction, Q.30 signed
  localparam int MAG_W   = 53;
  localparam int POS_W   = 6;
  localparam int C_W     = 30;                    // block-scaled magnitude
  localparam int SQ_W    = 2 * C_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int LEN_W   = 31;
  localparam int ISQ_STEPS = 32;
  localparam int Q_W     = 18;
  localparam int DIV_STEPS = Q_W;
  localparam int DIV_W   = 49;
  localparam int DIR_W   = 18;
  localparam int NORM_TOP = 29;                   // largest magnitude in [2^29, 2^30)
  localparam int UNIT    = 65536;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = VEC_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEW    = 3'd0,
    REG_SIDE    = 3'd1,
    REG_UP      = 3'd2,
    REG_SCALE_X = 3'd3,
    REG_SCALE_Y = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } norm_sb_t;

  typedef logic [2:0][MAG_W-1:0] mag3_t;
  typedef logic [2:0][C_W-1:0]   c3_t;
  typedef logic [2:0][Q_W-1:0]   q3_t;

endpackage

FILE: src/pinhole_primary_ray_direction_top.sv
`timescale 1ns / 1ps
// An input beat passes through the front, normalize, square root and divide
// pipelines and then the output register.
// Throughput: one beat per cycle; the whole pipeline advances together, held
// only while the output register is full and not taken.
// Reset (rst_n low, synchronous) clears all valid bits and configuration to zero.
module pinhole_primary_ray_direction_top import prpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,    // pixel_x, pixel_y
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [55:0]           out_tdata,   // dir_x, dir_y, dir_z, zero pad
  output logic                  out_tuser,   // degenerate
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic en;
  logic [VEC_W-1:0] view_r, side_r, up_r;
  logic [SCALE_W-1:0] scale_x_r, scale_y_r;

  logic f_v, n_v, s_v, d_v;
  mag3_t f_mag;
  logic [2:0] f_neg;
  logic [SUM_W-1:0] n_sum;
  c3_t n_c, s_c;
  norm_sb_t n_sb, s_sb, d_sb;
  logic [LEN_W-1:0] s_len;
  q3_t d_q;

  logic out_v_r, degen_r;
  logic [2:0][DIR_W-1:0] dir_r, dir_nxt;

  assign en        = !out_v_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_r    <= '0;
      side_r    <= '0;
      up_r      <= '0;
      scale_x_r <= '0;
      scale_y_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_VIEW:    view_r    <= cfg_data;
        REG_SIDE:    side_r    <= cfg_data;
        REG_UP:      up_r      <= cfg_data;
        REG_SCALE_X: scale_x_r <= cfg_data[SCALE_W-1:0];
        REG_SCALE_Y: scale_y_r <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  prpd_front u_front (
    .clk, .rst_n, .en,
    .in_v     (in_tvalid),
    .pixel_x  (in_tdata[15:0]),
    .pixel_y  (in_tdata[31:16]),
    .view_vec (view_r),
    .side_vec (side_r),
    .up_vec   (up_r),
    .scale_x  (scale_x_r),
    .scale_y  (scale_y_r),
    .out_v    (f_v),
    .out_mag  (f_mag),
    .out_neg  (f_neg)
  );

  prpd_norm u_norm (
    .clk, .rst_n, .en,
    .in_v    (f_v),
    .in_mag  (f_mag),
    .in_neg  (f_neg),
    .out_v   (n_v),
    .out_sum (n_sum),
    .out_c   (n_c),
    .out_sb  (n_sb)
  );

  prpd_isqrt u_isqrt (
    .clk, .rst_n, .en,
    .in_v    (n_v),
    .in_sum  (n_sum),
    .in_c    (n_c),
    .in_sb   (n_sb),
    .out_v   (s_v),
    .out_len (s_len),
    .out_c   (s_c),
    .out_sb  (s_sb)
  );

  prpd_div u_div (
    .clk, .rst_n, .en,
    .in_v   (s_v),
    .in_len (s_len),
    .in_c   (s_c),
    .in_sb  (s_sb),
    .out_v  (d_v),
    .out_q  (d_q),
    .out_sb (d_sb)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [Q_W-1:0] qs;
      qs = (d_q[k] > Q_W'(UNIT)) ? Q_W'(UNIT) : d_q[k];
      if (d_sb.degen) begin
        dir_nxt[k] = '0;
      end else begin
        dir_nxt[k] = d_sb.neg[k] ? DIR_W'(-qs) : DIR_W'(qs);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir_r   <= dir_nxt;
      degen_r <= d_sb.degen;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, dir_r[2], dir_r[1], dir_r[0]};
  assign out_tuser  = degen_r;

  a_ready_follows_out : assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("degenerate result with nonzero direction");

  a_dir_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(dir_r[0]) >= -UNIT && $signed(dir_r[0]) <= UNIT &&
                    $signed(dir_r[1]) >= -UNIT && $signed(dir_r[1]) <= UNIT &&
                    $signed(dir_r[2]) >= -UNIT && $signed(dir_r[2]) <= UNIT))
    else $error("direction component out of unit range");

endmodule

FILE: src/prpd_front.sv
`timescale 1ns / 1ps
module prpd_front import prpd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  logic [PIX_W-1:0]   pixel_x,
  input  logic [PIX_W-1:0]   pixel_y,
  input  logic [VEC_W-1:0]   view_vec,
  input  logic [VEC_W-1:0]   side_vec,
  input  logic [VEC_W-1:0]   up_vec,
  input  logic [SCALE_W-1:0] scale_x,
  input  logic [SCALE_W-1:0] scale_y,
  output logic               out_v,
  output mag3_t              out_mag,
  output logic [2:0]         out_neg
);

  logic [3:0] v_r;
  logic [PROD_W-1:0] px_r, py_r;
  logic signed [WS_W-1:0] w_r, h_r, w_nxt, h_nxt;
  logic [PROD_W-1:0] prx, pry;
  logic signed [MP_W-1:0] ps_r [3];
  logic signed [MP_W-1:0] pu_r [3];
  logic signed [COMP_W-1:0] vc_r [3];
  mag3_t mag_r;
  logic [2:0] neg_r;

  assign prx = PROD_W'(px_r + PROD_W'(32'h20000));
  assign pry = PROD_W'(py_r + PROD_W'(32'h20000));
  assign w_nxt = $signed({1'b0, prx[PROD_W-1:18]}) - WS_W'(UNIT);
  assign h_nxt = $signed({1'b0, pry[PROD_W-1:18]}) - WS_W'(UNIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= PROD_W'((PIX_W + 1)'(pixel_x) + (PIX_W + 1)'(8)) * PROD_W'(scale_x);
      py_r <= PROD_W'((PIX_W + 1)'(pixel_y) + (PIX_W + 1)'(8)) * PROD_W'(scale_y);
      w_r  <= w_nxt;
      h_r  <= h_nxt;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_comp
    logic signed [COMP_W-1:0] sc, uc;
    logic signed [MP_W-1:0]   ps_nxt, pu_nxt;
    logic signed [D_W-1:0]    d_nxt;
    assign sc = side_vec[k*COMP_W +: COMP_W];
    assign uc = up_vec[k*COMP_W +: COMP_W];
    assign ps_nxt = sc * w_r;
    assign pu_nxt = uc * h_r;
    assign d_nxt = $signed({{(D_W-COMP_W-16){vc_r[k][COMP_W-1]}}, vc_r[k], 16'h0})
                 - $signed({{(D_W-MP_W){ps_r[k][MP_W-1]}}, ps_r[k]})
                 - $signed({{(D_W-MP_W){pu_r[k][MP_W-1]}}, pu_r[k]});
    always_ff @(posedge clk) begin
      if (en) begin
        ps_r[k]  <= ps_nxt;
        pu_r[k]  <= pu_nxt;
        vc_r[k]  <= view_vec[k*COMP_W +: COMP_W];
        neg_r[k] <= d_nxt[D_W-1];
        mag_r[k] <= d_nxt[D_W-1] ? MAG_W'(-d_nxt) : MAG_W'(d_nxt);
      end
    end
  end

  assign out_v   = v_r[3];
  assign out_mag = mag_r;
  assign out_neg = neg_r;

endmodule

FILE: src/prpd_norm.sv
`timescale 1ns / 1ps
module prpd_norm import prpd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  mag3_t            in_mag,
  input  logic [2:0]       in_neg,
  output logic             out_v,
  output logic [SUM_W-1:0] out_sum,
  output c3_t              out_c,
  output norm_sb_t         out_sb
);

  logic [3:0] v_r;
  logic [MAG_W-1:0] m_all;
  logic [POS_W-1:0] pos_nxt, pos_r;
  logic zero_r;
  mag3_t mag_r;
  logic [2:0] neg_r;
  c3_t c_r, c2_r, c3_r, c_nxt;
  norm_sb_t sb_r, sb2_r, sb3_r;
  logic [2:0][SQ_W-1:0] sq_r;
  logic [SUM_W-1:0] sum_r;

  assign m_all = in_mag[0] | in_mag[1] | in_mag[2];

  // leading one of the OR equals leading one of the largest magnitude
  always_comb begin
    pos_nxt = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m_all[i]) pos_nxt = POS_W'(i);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (pos_r >= POS_W'(NORM_TOP)) begin
        c_nxt[k] = C_W'(mag_r[k] >> (pos_r - POS_W'(NORM_TOP)));
      end else begin
        c_nxt[k] = C_W'(mag_r[k] << (POS_W'(NORM_TOP) - pos_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r  <= pos_nxt;
      zero_r <= (m_all == '0);
      mag_r  <= in_mag;
      neg_r  <= in_neg;
      c_r    <= c_nxt;
      sb_r   <= '{neg: neg_r, degen: zero_r};
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= SQ_W'(c_r[k]) * SQ_W'(c_r[k]);
      end
      c2_r   <= c_r;
      sb2_r  <= sb_r;
      sum_r  <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
      c3_r   <= c2_r;
      sb3_r  <= sb2_r;
    end
  end

  assign out_v   = v_r[3];
  assign out_sum = sum_r;
  assign out_c   = c3_r;
  assign out_sb  = sb3_r;

endmodule

FILE: src/prpd_isqrt.sv
`timescale 1ns / 1ps
module prpd_isqrt import prpd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  logic [SUM_W-1:0] in_sum,
  input  c3_t              in_c,
  input  norm_sb_t         in_sb,
  output logic             out_v,
  output logic [LEN_W-1:0] out_len,
  output c3_t              out_c,
  output norm_sb_t         out_sb
);

  localparam int RW = 2 * ISQ_STEPS - 1;

  logic [ISQ_STEPS-1:0] v_r;
  logic [RW-1:0] rem_r [ISQ_STEPS];
  logic [RW-1:0] res_r [ISQ_STEPS];
  c3_t c_r [ISQ_STEPS];
  norm_sb_t sb_r [ISQ_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[ISQ_STEPS-2:0], in_v};
    end
  end

  // one result bit per stage, digit weight 4^(31-k)
  for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
    localparam logic [RW-1:0] BIT = RW'(1) << (RW - 1 - 2 * k);
    logic [RW-1:0] rem_in, res_in, tst;
    c3_t c_in;
    norm_sb_t sb_in;
    if (k == 0) begin : g_first
      assign rem_in = RW'(in_sum);
      assign res_in = '0;
      assign c_in   = in_c;
      assign sb_in  = in_sb;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign res_in = res_r[k-1];
      assign c_in   = c_r[k-1];
      assign sb_in  = sb_r[k-1];
    end
    assign tst = res_in + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= tst) begin
          rem_r[k] <= rem_in - tst;
          res_r[k] <= (res_in >> 1) + BIT;
        end else begin
          rem_r[k] <= rem_in;
          res_r[k] <= res_in >> 1;
        end
        c_r[k]  <= c_in;
        sb_r[k] <= sb_in;
      end
    end
  end

  assign out_v   = v_r[ISQ_STEPS-1];
  assign out_len = res_r[ISQ_STEPS-1][LEN_W-1:0];
  assign out_c   = c_r[ISQ_STEPS-1];
  assign out_sb  = sb_r[ISQ_STEPS-1];

endmodule

FILE: src/prpd_div.sv
`timescale 1ns / 1ps
module prpd_div import prpd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  logic [LEN_W-1:0] in_len,
  input  c3_t              in_c,
  input  norm_sb_t         in_sb,
  output logic             out_v,
  output q3_t              out_q,
  output norm_sb_t         out_sb
);

  logic [DIV_STEPS-1:0] v_r;
  logic [2:0][DIV_W-1:0] rem_r [DIV_STEPS];
  q3_t quo_r [DIV_STEPS];
  logic [LEN_W-1:0] len_r [DIV_STEPS];
  norm_sb_t sb_r [DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DIV_STEPS-2:0], in_v};
    end
  end

  // restoring division, quotient bit Q_W-1-j decided in stage j
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [2:0][DIV_W-1:0] rem_in;
    q3_t quo_in;
    logic [LEN_W-1:0] len_in;
    norm_sb_t sb_in;
    logic [DIV_W-1:0] dvs;
    if (j == 0) begin : g_first
      for (genvar i = 0; i < 3; i++) begin : g_num
        assign rem_in[i] = DIV_W'({in_c[i], 16'h0}) + DIV_W'(in_len >> 1);
      end
      assign quo_in = '0;
      assign len_in = in_len;
      assign sb_in  = in_sb;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign quo_in = quo_r[j-1];
      assign len_in = len_r[j-1];
      assign sb_in  = sb_r[j-1];
    end
    assign dvs = DIV_W'(len_in) << (Q_W - 1 - j);
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (rem_in[i] >= dvs) begin
            rem_r[j][i] <= rem_in[i] - dvs;
            quo_r[j][i] <= quo_in[i] | (Q_W'(1) << (Q_W - 1 - j));
          end else begin
            rem_r[j][i] <= rem_in[i];
            quo_r[j][i] <= quo_in[i];
          end
        end
        len_r[j] <= len_in;
        sb_r[j]  <= sb_in;
      end
    end
  end

  assign out_v  = v_r[DIV_STEPS-1];
  assign out_q  = quo_r[DIV_STEPS-1];
  assign out_sb = sb_r[DIV_STEPS-1];

endmodule
